// File: hw/rtl/ilvc_pkg.sv
// ----------------------------------------------------------------------------
// ilvc_pkg
// Shared types and constants for the instrument last-value cache.
// ----------------------------------------------------------------------------
package ilvc_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [39:0] PRICE_MAX = 40'd999999999999;
    localparam logic [49:0] QTY_MAX   = 50'd999999999999999;
    localparam logic [59:0] TIME_MAX  = 60'd999999999999999999;

    // Result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_CROSSED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [55:0] key_word3;
        logic [4:0]  key_length;
        logic [39:0] bid_price;
        logic [39:0] ask_price;
        logic [39:0] last_price;
        logic [49:0] volume;
        logic [59:0] quote_time;
    } t_quote;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sequence_res;
        logic [4:0]  change_flags;
        logic [10:0] entry_index;
        logic [39:0] out_bid;
        logic [39:0] out_ask;
        logic [39:0] out_last;
        logic [49:0] out_volume;
        logic [59:0] out_time;
    } t_result;

endpackage

// File: hw/rtl/ilvc_stream_if.sv
// ----------------------------------------------------------------------------
// ilvc_stream_if
// Valid/ready stream carrying one payload beat.
// ----------------------------------------------------------------------------
interface ilvc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ilvc_hash.sv
// ----------------------------------------------------------------------------
// ilvc_hash
// FNV-1a over the code, one byte a cycle, then hash mod table size by a
// reciprocal multiply: quotient estimate, remainder, then a correcting subtract.
// ----------------------------------------------------------------------------
module ilvc_hash import ilvc_pkg::*; #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int KEY_BYTES_MAX = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [(KEY_BYTES_MAX-1)*8-1:0]   i_key,
    input  logic [4:0]                       i_len,
    output logic                             o_done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_slot
);
    localparam int KW = (KEY_BYTES_MAX - 1) * 8;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [31:0] TV = 32'(TABLE_ENTRIES);
    // floor(2^32 / entries): quotient estimate is exact or one short
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_ENTRIES);

    typedef enum logic [2:0] {H_IDLE, H_BYTE, H_QUO, H_REM, H_FIX} t_hstate;

    t_hstate         r_state;
    logic [31:0]     r_h;
    logic [KW-1:0]   r_sh;
    logic [4:0]      r_left;
    logic [31:0]     r_q;
    logic [31:0]     r_r;
    logic [IW-1:0]   r_rem;
    logic            r_done;
    logic [31:0]     n_mix;
    logic [63:0]     n_prod;
    logic [31:0]     n_qn;
    logic [31:0]     n_fix;

    assign n_mix  = r_h ^ {24'd0, r_sh[7:0]};
    assign n_prod = {32'd0, r_h} * {32'd0, RECIP};
    assign n_qn   = r_q * TV;
    assign n_fix  = (r_r >= TV) ? (r_r - TV) : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == H_FIX);
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_h     <= FNV_BASIS;
                        r_sh    <= i_key;
                        r_left  <= i_len;
                        r_state <= (i_len == 5'd0) ? H_QUO : H_BYTE;
                    end
                end
                H_BYTE: begin
                    r_h    <= n_mix * FNV_PRIME;
                    r_sh   <= r_sh >> 8;
                    r_left <= r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        r_state <= H_QUO;
                    end
                end
                H_QUO: begin
                    r_q     <= n_prod[63:32];
                    r_state <= H_REM;
                end
                H_REM: begin
                    // remainder below twice the table size here
                    r_r     <= r_h - n_qn;
                    r_state <= H_FIX;
                end
                H_FIX: begin
                    r_rem   <= n_fix[IW-1:0];
                    r_state <= H_IDLE;
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;
endmodule

// File: hw/rtl/instrument_last_value_cache.sv
// ----------------------------------------------------------------------------
// instrument_last_value_cache
// Last-value cache: FNV-1a hashed, linear-probed table of instrument quotes.
// ----------------------------------------------------------------------------
// Flow: accept, hash (byte loop, then the reciprocal reduction), then per probe
//   a registered read of the one table read port and a compare; a crossed quote
//   skips the table and goes straight to the result register.
// Throughput: one quote at a time; the next beat is taken the cycle after the
//   result is parked.
// Reset: control cleared, then a clearing pass zeroes every table row while
//   the input is held not ready.
module instrument_last_value_cache import ilvc_pkg::*; #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int KEY_BYTES_MAX = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ilvc_stream_if.sink    i_quote,
    ilvc_stream_if.source  o_result
);
    localparam int KB = KEY_BYTES_MAX - 1;
    localparam int KW = KB * 8;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_E = IW'(TABLE_ENTRIES - 1);

    // One table row: occupancy, code and last published values
    typedef struct packed {
        logic          used;
        logic [4:0]    len;
        logic [KW-1:0] key;
        logic [39:0]   bid;
        logic [39:0]   ask;
        logic [39:0]   last;
        logic [49:0]   vol;
        logic [59:0]   tim;
    } t_row;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_RD, S_CMP, S_DONE
    } t_state;

    t_row   r_mem [TABLE_ENTRIES];
    t_row   r_row;

    t_state        r_state;
    logic [IW-1:0] r_e;      // probe slot, also the clear sweep address
    logic [IW-1:0] r_cnt;    // probes done
    logic          r_start;
    logic [KW-1:0] r_key;
    logic [4:0]    r_len;
    logic [39:0]   r_bid, r_ask, r_last;
    logic [49:0]   r_vol;
    logic [59:0]   r_tim;
    logic [1:0]    r_status;
    logic [4:0]    r_flags;
    logic [31:0]   r_seq;
    t_result       r_out;
    logic          r_out_valid;

    logic          hash_done;
    logic [IW-1:0] hash_slot;

    // Input side: saturate and mask at accept
    logic [247:0]  n_key_all;
    logic [KW-1:0] n_key;
    logic [4:0]    n_len;
    logic [39:0]   n_bid, n_ask, n_last;
    logic [49:0]   n_vol;
    logic [59:0]   n_tim;

    // Probe compare
    logic          hit_free, hit_match, w_we;
    logic [IW-1:0] w_addr;
    t_row          w_data, n_row;
    logic [4:0]    n_flags;

    // Handshake and result parking
    logic          n_crossed, n_start, n_park, n_out_valid;
    t_result       n_out;

    always_comb begin
        n_key_all = {i_quote.data.key_word3, i_quote.data.key_word2,
                     i_quote.data.key_word1, i_quote.data.key_word0};
        n_len = (i_quote.data.key_length > 5'(KB)) ? 5'(KB) : i_quote.data.key_length;
        for (int i = 0; i < KB; i++) begin
            n_key[i*8 +: 8] = (5'(i) < n_len) ? n_key_all[i*8 +: 8] : 8'd0;
        end
        n_bid  = (i_quote.data.bid_price  > PRICE_MAX) ? PRICE_MAX : i_quote.data.bid_price;
        n_ask  = (i_quote.data.ask_price  > PRICE_MAX) ? PRICE_MAX : i_quote.data.ask_price;
        n_last = (i_quote.data.last_price > PRICE_MAX) ? PRICE_MAX : i_quote.data.last_price;
        n_vol  = (i_quote.data.volume     > QTY_MAX)   ? QTY_MAX   : i_quote.data.volume;
        n_tim  = (i_quote.data.quote_time > TIME_MAX)  ? TIME_MAX  : i_quote.data.quote_time;
    end

    // crossed only when both sides are quoted
    assign n_crossed   = (n_bid != 40'd0) && (n_ask != 40'd0) && (n_bid > n_ask);
    assign n_start     = (r_state == S_IDLE) && i_quote.valid && !n_crossed;
    // park once the output register is free or being emptied
    assign n_park      = (r_state == S_DONE) && (!r_out_valid || o_result.ready);
    assign n_out_valid = n_park || (r_out_valid && !o_result.ready);

    always_comb begin
        n_out        = '0;
        n_out.status = r_status;
        if (r_status == ST_ACCEPTED) begin
            n_out.sequence_res = r_seq;
            n_out.change_flags = r_flags;
            n_out.entry_index  = 11'(r_e);
            n_out.out_bid      = r_bid;
            n_out.out_ask      = r_ask;
            n_out.out_last     = r_last;
            n_out.out_volume   = r_vol;
            n_out.out_time     = r_tim;
        end
    end

    always_comb begin
        hit_free  = !r_row.used;
        hit_match = r_row.used && (r_row.len == r_len) && (r_row.key == r_key);
        n_flags[0] = r_row.bid  != r_bid;
        n_flags[1] = r_row.ask  != r_ask;
        n_flags[2] = r_row.last != r_last;
        n_flags[3] = r_row.vol  != r_vol;
        n_flags[4] = r_row.tim  >  r_tim;
        n_row = '{used: 1'b1, len: r_len, key: r_key, bid: r_bid, ask: r_ask,
                  last: r_last, vol: r_vol, tim: r_tim};
        w_addr = r_e;
        w_we   = (r_state == S_CLEAR) ||
                 ((r_state == S_CMP) && (hit_free || hit_match));
        w_data = (r_state == S_CLEAR) ? t_row'('0) : n_row;
    end

    // Table memory: one write, one registered read at the probe slot
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_row <= r_mem[r_e];
    end

    ilvc_hash #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_key   (r_key),
        .i_len   (r_len),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_e         <= '0;
            r_start     <= 1'b0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            case (r_state)
                S_CLEAR: begin
                    if (r_e == LAST_E) begin
                        r_e     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_e <= r_e + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_quote.valid) begin
                        r_key   <= n_key;
                        r_len   <= n_len;
                        r_bid   <= n_bid;
                        r_ask   <= n_ask;
                        r_last  <= n_last;
                        r_vol   <= n_vol;
                        r_tim   <= n_tim;
                        r_flags <= '0;
                        if (n_crossed) begin
                            r_status <= ST_CROSSED;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_e     <= hash_slot;
                        r_cnt   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (hit_free || hit_match) begin
                        r_flags  <= n_flags;
                        r_status <= ST_ACCEPTED;
                        r_state  <= S_DONE;
                    end else if (r_cnt == LAST_E) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_e     <= (r_e == LAST_E) ? '0 : r_e + 1'b1;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    // park the result once the output register is free
                    if (n_park) begin
                        r_out <= n_out;
                        if (r_status == ST_ACCEPTED) begin
                            r_seq <= r_seq + 32'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_quote.ready  = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
endmodule

// File: bench/instrument_last_value_cache_test.sv
// ----------------------------------------------------------------------------
// instrument_last_value_cache_test
// Self-checking bench for the quote last-value cache. Quotes go in on a
// valid/ready stream with bursty timing; an in-bench model of the hashed
// table works out each result beat, which is checked field by field against
// the beats that come out under a stalling receiver.
// ----------------------------------------------------------------------------
module instrument_last_value_cache_test;
    import ilvc_pkg::*;

    localparam int ENTRIES    = 2048;
    localparam int IDLE_LIMIT = 8000;     // clearing pass + long hold + slow probe
    localparam int POOL_SIZE  = 48;

    logic i_clk;
    logic i_rst_n;

    ilvc_stream_if #(.t_payload(t_quote))  quote_if ();
    ilvc_stream_if #(.t_payload(t_result)) result_if ();

    instrument_last_value_cache dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_quote  (quote_if),
        .o_result (result_if)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ------------------------------------------------------------------
    // Cache model: same table, same probe order, key held as 256 bits
    // with byte i at bits 8i+7:8i.
    // ------------------------------------------------------------------
    logic         row_used   [ENTRIES];
    logic [255:0] row_key    [ENTRIES];
    logic [4:0]   row_len    [ENTRIES];
    logic [39:0]  row_bid    [ENTRIES];
    logic [39:0]  row_ask    [ENTRIES];
    logic [39:0]  row_last   [ENTRIES];
    logic [49:0]  row_volume [ENTRIES];
    logic [59:0]  row_time   [ENTRIES];
    logic [31:0]  next_seq;

    t_result pending_results[$];
    int      errors;

    function automatic logic [255:0] len_mask(int len);
        logic [255:0] m;
        m = '0;
        for (int i = 0; i < len; i++) m[i*8 +: 8] = 8'hFF;
        return m;
    endfunction

    function automatic logic [31:0] fnv1a(logic [255:0] key, int len);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < len; i++) begin
            h = h ^ {24'd0, key[i*8 +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic logic [255:0] quote_key(t_quote q);
        return {8'd0, q.key_word3, q.key_word2, q.key_word1, q.key_word0};
    endfunction

    function automatic t_result predict_quote(t_quote q);
        t_result      r;
        logic [39:0]  bid, ask, lst;
        logic [49:0]  vol;
        logic [59:0]  tim;
        logic [255:0] key;
        int           len, slot, e;
        bit           found;
        r   = '0;
        bid = (q.bid_price  > PRICE_MAX) ? PRICE_MAX : q.bid_price;
        ask = (q.ask_price  > PRICE_MAX) ? PRICE_MAX : q.ask_price;
        lst = (q.last_price > PRICE_MAX) ? PRICE_MAX : q.last_price;
        vol = (q.volume     > QTY_MAX)   ? QTY_MAX   : q.volume;
        tim = (q.quote_time > TIME_MAX)  ? TIME_MAX  : q.quote_time;
        if (bid != 0 && ask != 0 && bid > ask) begin
            r.status = ST_CROSSED;
            return r;
        end
        len   = q.key_length;
        key   = quote_key(q) & len_mask(len);
        slot  = fnv1a(key, len) % ENTRIES;
        found = 1'b0;
        e     = 0;
        for (int i = 0; i < ENTRIES && !found; i++) begin
            e = (slot + i) % ENTRIES;
            if (!row_used[e]) begin
                row_used[e] = 1'b1;
                row_key[e]  = key;
                row_len[e]  = len[4:0];
                found       = 1'b1;
            end else if (row_len[e] == len[4:0] && row_key[e] == key) begin
                found = 1'b1;
            end
        end
        if (!found) begin
            r.status = ST_FULL;
            return r;
        end
        r.status          = ST_ACCEPTED;
        r.sequence_res    = next_seq;
        r.change_flags[0] = row_bid[e]    != bid;
        r.change_flags[1] = row_ask[e]    != ask;
        r.change_flags[2] = row_last[e]   != lst;
        r.change_flags[3] = row_volume[e] != vol;
        r.change_flags[4] = row_time[e]   >  tim;
        r.entry_index     = e[10:0];
        r.out_bid         = bid;
        r.out_ask         = ask;
        r.out_last        = lst;
        r.out_volume      = vol;
        r.out_time        = tim;
        row_bid[e]    = bid;
        row_ask[e]    = ask;
        row_last[e]   = lst;
        row_volume[e] = vol;
        row_time[e]   = tim;
        next_seq      = next_seq + 1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got = result_if.data;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", got.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.sequence_res != want.sequence_res)
                    report_mismatch("sequence", got.sequence_res, want.sequence_res);
                if (got.change_flags != want.change_flags)
                    report_mismatch("flags", got.change_flags, want.change_flags);
                if (got.entry_index != want.entry_index)
                    report_mismatch("entry", got.entry_index, want.entry_index);
                if (got.out_bid != want.out_bid)
                    report_mismatch("bid", got.out_bid, want.out_bid);
                if (got.out_ask != want.out_ask)
                    report_mismatch("ask", got.out_ask, want.out_ask);
                if (got.out_last != want.out_last)
                    report_mismatch("last", got.out_last, want.out_last);
                if (got.out_volume != want.out_volume)
                    report_mismatch("volume", got.out_volume, want.out_volume);
                if (got.out_time != want.out_time)
                    report_mismatch("time", got.out_time, want.out_time);
            end
        end
    end

    // Watchdog: cycles with no beat on either side.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((quote_if.valid && quote_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, re-drawn whenever its counter runs out; a test can
    // ask for a long hold-off which is counted down here.
    // ------------------------------------------------------------------
    int hold_off;
    int rx_mode  = 0;
    int rx_count = 0;
    always @(negedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode  <= $urandom_range(0, 2);
            rx_count <= 64;
        end else begin
            rx_count <= rx_count - 1;
        end
        if (hold_off > 0) begin
            result_if.ready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            case (rx_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= ($urandom_range(0, 3) != 0);
                default: result_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps between them.
    // ------------------------------------------------------------------
    int burst_left;

    task automatic send_quote(t_quote q);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                quote_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        quote_if.valid <= 1'b1;
        quote_if.data  <= q;
        do @(posedge i_clk); while (!quote_if.ready);
        pending_results.push_back(predict_quote(q));
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        quote_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Instrument codes: a pool of known keys, some sharing a start slot
    // with key 0 so that probing past a used row is exercised.
    // ------------------------------------------------------------------
    logic [255:0] pool_key [POOL_SIZE];
    int           pool_len [POOL_SIZE];

    function automatic logic [255:0] random_bits();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic build_pool();
        logic [255:0] k;
        int           len;
        pool_len[0] = 6;
        pool_key[0] = random_bits() & len_mask(6);
        pool_len[1] = 0;  pool_key[1] = '0;                       // empty code
        pool_len[2] = 31; pool_key[2] = len_mask(31);             // all-ones bytes
        pool_len[3] = 8;  pool_key[3] = 256'h00_41_00_00_42_00_43_00; // zeros inside
        pool_len[4] = 7;  pool_key[4] = pool_key[3] & len_mask(7);   // prefix of 3
        for (int i = 5; i < 8; i++) begin
            // same start slot as key 0, different code
            do begin
                len = $urandom_range(1, 31);
                k   = random_bits() & len_mask(len);
            end while ((fnv1a(k, len) % ENTRIES) != (fnv1a(pool_key[0], 6) % ENTRIES)
                       || (len == 6 && k == pool_key[0]));
            pool_len[i] = len;
            pool_key[i] = k;
        end
        for (int i = 8; i < POOL_SIZE; i++) begin
            pool_len[i] = $urandom_range(0, 31);
            pool_key[i] = random_bits() & len_mask(pool_len[i]);
        end
    endtask

    // Junk beyond the length must be ignored by the block.
    function automatic t_quote with_key(t_quote q, logic [255:0] key, int len, bit junk);
        logic [255:0] k;
        k = key & len_mask(len);
        if (junk) k = k | (random_bits() & ~len_mask(len));
        q.key_word0  = k[63:0];
        q.key_word1  = k[127:64];
        q.key_word2  = k[191:128];
        q.key_word3  = k[247:192];
        q.key_length = len[4:0];
        return q;
    endfunction

    function automatic logic [63:0] pick_value(int width, logic [63:0] top);
        logic [63:0] ones;
        ones = (64'd1 << width) - 1;
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return top;
            2:       return top + 1;
            3:       return ones;
            4, 5:    return $urandom_range(0, 3);
            default: return {$urandom, $urandom} & ones;
        endcase
    endfunction

    function automatic t_quote random_values(t_quote q);
        q.bid_price  = 40'(pick_value(40, 64'(PRICE_MAX)));
        q.ask_price  = 40'(pick_value(40, 64'(PRICE_MAX)));
        q.last_price = 40'(pick_value(40, 64'(PRICE_MAX)));
        q.volume     = 50'(pick_value(50, 64'(QTY_MAX)));
        q.quote_time = 60'(pick_value(60, 64'(TIME_MAX)));
        // mostly uncrossed so that the table sees the bulk of the traffic
        if ($urandom_range(0, 3) != 0 && q.bid_price > q.ask_price && q.ask_price != 0)
            q.ask_price = q.bid_price;
        return q;
    endfunction

    function automatic t_quote quote_of(int p, logic [39:0] bid, logic [39:0] ask,
                                        logic [39:0] lst, logic [49:0] vol,
                                        logic [59:0] tim);
        t_quote q;
        q = '0;
        q.bid_price = bid; q.ask_price = ask; q.last_price = lst;
        q.volume = vol; q.quote_time = tim;
        return with_key(q, pool_key[p], pool_len[p], 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_extremes();
        send_quote(quote_of(0, PRICE_MAX, PRICE_MAX, PRICE_MAX, QTY_MAX, TIME_MAX));
        send_quote(quote_of(0, '1, '1, '1, '1, '1));        // saturates to same
        send_quote(quote_of(0, 0, 0, 0, 0, 0));              // older timestamp
        send_quote(quote_of(1, 7, 9, 8, 100, 5));            // empty code
        send_quote(quote_of(2, 1, 1, 1, 1, 1));              // longest code
        send_quote(quote_of(3, 2, 2, 2, 2, 2));              // zeros inside code
        send_quote(quote_of(4, 3, 3, 3, 3, 3));              // shorter prefix
    endtask

    task automatic test_crossed();
        send_quote(quote_of(0, 5, 3, 1, 1, 1));              // crossed
        send_quote(quote_of(0, 5, 0, 1, 1, 1));              // ask zero: taken
        send_quote(quote_of(0, 0, 3, 1, 1, 1));              // bid zero: taken
        send_quote(quote_of(0, PRICE_MAX + 1, PRICE_MAX, 1, 1, 1)); // equal once clamped
        send_quote(quote_of(0, '1, 40'd1, 1, 1, 1));         // crossed after clamp
    endtask

    task automatic test_collisions();
        for (int i = 5; i < 8; i++) send_quote(quote_of(i, i, i, i, i, i));
        for (int i = 5; i < 8; i++) send_quote(quote_of(i, i, i + 1, i, i, i - 1));
    endtask

    task automatic test_repeat_values();
        send_quote(quote_of(3, 2, 2, 2, 2, 2));              // nothing changed
        send_quote(quote_of(3, 2, 2, 2, 2, 3));              // newer time only
    endtask

    task automatic test_long_hold();
        t_quote q;
        hold_off = 500;
        for (int i = 0; i < 6; i++) begin
            q = with_key('0, pool_key[$urandom_range(8, POOL_SIZE - 1)], 0, 1'b0);
            q = with_key(random_values(q), pool_key[8 + i], pool_len[8 + i], 1'b1);
            send_quote(q);
        end
    endtask

    task automatic test_random(int count);
        t_quote q;
        int     p, len;
        for (int n = 0; n < count; n++) begin
            q = random_values('0);
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(0, 31);
                q   = with_key(q, random_bits(), len, 1'b1);
            end else begin
                p = $urandom_range(0, POOL_SIZE - 1);
                q = with_key(q, pool_key[p], pool_len[p], $urandom_range(0, 1));
            end
            send_quote(q);
            if (n == count / 2) wait_drained();   // sender pauses till all are back
        end
    endtask

    initial begin
        errors      = 0;
        burst_left  = 0;
        hold_off    = 0;
        next_seq    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            row_used[i] = 1'b0;  row_key[i] = '0;  row_len[i] = '0;
            row_bid[i] = '0;  row_ask[i] = '0;  row_last[i] = '0;
            row_volume[i] = '0;  row_time[i] = '0;
        end
        i_rst_n         = 1'b0;
        quote_if.valid  = 1'b0;
        quote_if.data   = '0;
        result_if.ready = 1'b0;
        build_pool();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_crossed();
        test_collisions();
        test_repeat_values();
        test_long_hold();
        wait_drained();
        test_random(960);
        wait_drained();
        repeat (120) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
